// ----- sv/alx_pkg.sv -----
`default_nettype none
package alx_pkg;

    localparam int POSITION_BITS_DEFAULT = 16;
    localparam int VALUE_BITS_DEFAULT    = 32;

    typedef enum logic [3:0] {
        KIND_END    = 4'd0,
        KIND_NUMBER = 4'd1,
        KIND_SPACE  = 4'd2,
        KIND_PLUS   = 4'd3,
        KIND_MINUS  = 4'd4,
        KIND_STAR   = 4'd5,
        KIND_SLASH  = 4'd6,
        KIND_BAD    = 4'd7,
        KIND_OPEN   = 4'd8,
        KIND_CLOSE  = 4'd9
    } kind_t;

    typedef enum logic [2:0] {
        MODE_NONE   = 3'b001,
        MODE_NUMBER = 3'b010,
        MODE_SPACE  = 3'b100
    } run_mode_t;

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_OPEN  = 8'h28;
    localparam logic [7:0] CHAR_CLOSE = 8'h29;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    function automatic kind_t single_kind(input logic [7:0] c);
        kind_t k;
        case (c)
            CHAR_PLUS:  k = KIND_PLUS;
            CHAR_MINUS: k = KIND_MINUS;
            CHAR_STAR:  k = KIND_STAR;
            CHAR_SLASH: k = KIND_SLASH;
            CHAR_OPEN:  k = KIND_OPEN;
            CHAR_CLOSE: k = KIND_CLOSE;
            default:    k = KIND_BAD;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

// ----- sv/alx_in_if.sv -----
`default_nettype none
interface alx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_text;

    modport source (output valid, output ch, output end_of_text, input ready);
    modport sink (input valid, input ch, input end_of_text, output ready);
endinterface
`default_nettype wire

// ----- sv/alx_out_if.sv -----
`default_nettype none
interface alx_out_if
    import alx_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT,
    parameter int VALUE_BITS    = VALUE_BITS_DEFAULT
);
    logic                         valid;
    logic                         ready;
    kind_t                        kind;
    logic [POSITION_BITS-1:0]     position;
    logic [POSITION_BITS-1:0]     run_length;
    logic signed [VALUE_BITS-1:0] value;
    logic                         overflow;
    logic                         last;

    modport source (output valid, output kind, output position, output run_length,
                    output value, output overflow, output last, input ready);
    modport sink (input valid, input kind, input position, input run_length,
                  input value, input overflow, input last, output ready);
endinterface
`default_nettype wire

// ----- sv/arithmetic_expression_lexer.sv -----
`default_nettype none
// Channel | Role | Item
// chars   | in   | one text byte (ch) or an end-of-text marker (end_of_text)
// tokens  | out  | one token: kind, position, run_length, value, overflow, last
//
// An item is tokenised while it sits in the input register, and its tokens are
// offered from a four-entry queue from the next cycle on; one item a cycle is sustained
// while the output keeps up. Two tokens from one item are offered in turn.
// The tokeniser stage fires only when the queue has room for two tokens, so a
// stalled output holds the input register and then the input channel.
// Reset (rst_n low, asynchronous) empties both stages and clears the run state.
module arithmetic_expression_lexer
    import alx_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT,
    parameter int VALUE_BITS    = VALUE_BITS_DEFAULT
)
(
    input  wire        clk,
    input  wire        rst_n,
    alx_in_if.sink     chars,
    alx_out_if.source  tokens
);

    localparam int ACC_BITS = VALUE_BITS - 1;
    localparam int PROD_BITS = ACC_BITS + 4;

    typedef struct packed {
        kind_t                        kind;
        logic [POSITION_BITS-1:0]     position;
        logic [POSITION_BITS-1:0]     run_length;
        logic signed [VALUE_BITS-1:0] value;
        logic                         overflow;
        logic                         last;
    } result_t;

    // Input register.
    logic       in_valid_reg;
    logic [7:0] in_ch_reg;
    logic       in_eot_reg;

    // Run state.
    run_mode_t                mode_reg, mode_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic [POSITION_BITS-1:0] index_reg, index_next;
    logic [ACC_BITS-1:0]      acc_reg, acc_next;
    logic                     sat_reg, sat_next;

    // Result queue.
    result_t    queue_reg [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] count_reg;

    logic    proc_fire;
    logic    pop;
    logic    in_fire;
    logic    is_digit;
    logic    is_space;
    logic    do_flush;
    logic    is_single;
    logic [1:0] n_results;
    result_t res0, res1;
    result_t flush_res, single_res, end_res;
    logic [POSITION_BITS-1:0] run_len;
    logic [ACC_BITS-1:0]      acc_base;
    logic                     sat_base;
    logic [PROD_BITS-1:0]     product;

    assign proc_fire   = in_valid_reg && (count_reg <= 3'd2);
    assign chars.ready = !in_valid_reg || proc_fire;
    assign in_fire     = chars.valid && chars.ready;
    assign pop         = tokens.valid && tokens.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (chars.ready)
        begin
            in_valid_reg <= chars.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_ch_reg  <= chars.ch;
            in_eot_reg <= chars.end_of_text;
        end
    end

    assign is_digit  = (in_ch_reg >= CHAR_ZERO) && (in_ch_reg <= CHAR_NINE);
    assign is_space  = (in_ch_reg == CHAR_SPACE) ||
                       ((in_ch_reg >= CHAR_TAB) && (in_ch_reg <= CHAR_CR));
    assign is_single = !is_digit && !is_space;
    assign do_flush  = ((mode_reg == MODE_NUMBER) && !is_digit) ||
                       ((mode_reg == MODE_SPACE) && !is_space);
    assign run_len   = index_reg - start_reg;

    always_comb
    begin
        flush_res = '0;
        if (mode_reg == MODE_NUMBER)
        begin
            flush_res.kind     = KIND_NUMBER;
            flush_res.position = start_reg;
            flush_res.value    = signed'({1'b0, acc_reg});
            flush_res.overflow = sat_reg;
        end
        else
        begin
            flush_res.kind     = KIND_SPACE;
            flush_res.position = index_reg;
            flush_res.value    = '1;
            flush_res.overflow = 1'b0;
        end
        flush_res.run_length = run_len;

        single_res            = '0;
        single_res.kind       = single_kind(in_ch_reg);
        single_res.position   = index_reg;
        single_res.run_length = POSITION_BITS'(1);
        single_res.value      = '1;

        end_res          = '0;
        end_res.kind     = KIND_END;
        end_res.position = index_reg;
    end

    always_comb
    begin
        res0      = single_res;
        res1      = single_res;
        n_results = 2'd0;
        if (in_eot_reg)
        begin
            if (mode_reg != MODE_NONE)
            begin
                res0      = flush_res;
                res1      = end_res;
                n_results = 2'd2;
            end
            else
            begin
                res0      = end_res;
                n_results = 2'd1;
            end
        end
        else if (do_flush)
        begin
            res0      = flush_res;
            n_results = is_single ? 2'd2 : 2'd1;
        end
        else if (is_single)
        begin
            n_results = 2'd1;
        end
        res0.last = (n_results == 2'd1);
        res1.last = 1'b1;
    end

    // The decimal step is a shift-and-add; anything past the top of the range saturates.
    always_comb
    begin
        acc_base   = (mode_reg == MODE_NUMBER) ? acc_reg : '0;
        sat_base   = (mode_reg == MODE_NUMBER) ? sat_reg : 1'b0;
        product    = {1'b0, acc_base, 3'b000} + {3'b000, acc_base, 1'b0}
                   + PROD_BITS'(in_ch_reg[3:0]);
        mode_next  = mode_reg;
        start_next = start_reg;
        index_next = index_reg;
        acc_next   = acc_reg;
        sat_next   = sat_reg;
        if (in_eot_reg)
        begin
            mode_next  = MODE_NONE;
            start_next = '0;
            index_next = '0;
            acc_next   = '0;
            sat_next   = 1'b0;
        end
        else
        begin
            index_next = index_reg + POSITION_BITS'(1);
            if (is_digit)
            begin
                mode_next = MODE_NUMBER;
                if (mode_reg != MODE_NUMBER)
                begin
                    start_next = index_reg;
                end
                if (product[PROD_BITS-1:ACC_BITS] != '0)
                begin
                    acc_next = '1;
                    sat_next = 1'b1;
                end
                else
                begin
                    acc_next = product[ACC_BITS-1:0];
                    sat_next = sat_base;
                end
            end
            else if (is_space)
            begin
                mode_next = MODE_SPACE;
                if (mode_reg != MODE_SPACE)
                begin
                    start_next = index_reg;
                end
            end
            else
            begin
                mode_next = MODE_NONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_NONE;
            start_reg <= '0;
            index_reg <= '0;
            acc_reg   <= '0;
            sat_reg   <= 1'b0;
        end
        else if (proc_fire)
        begin
            mode_reg  <= mode_next;
            start_reg <= start_next;
            index_reg <= index_next;
            acc_reg   <= acc_next;
            sat_reg   <= sat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire && (n_results != 2'd0))
        begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (proc_fire && (n_results == 2'd2))
        begin
            queue_reg[wr_ptr_reg + 2'd1] <= res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (proc_fire)
            begin
                wr_ptr_reg <= wr_ptr_reg + n_results;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + (proc_fire ? {1'b0, n_results} : 3'd0)
                       - (pop ? 3'd1 : 3'd0);
        end
    end

    assign tokens.valid      = (count_reg != 3'd0);
    assign tokens.kind       = queue_reg[rd_ptr_reg].kind;
    assign tokens.position   = queue_reg[rd_ptr_reg].position;
    assign tokens.run_length = queue_reg[rd_ptr_reg].run_length;
    assign tokens.value      = queue_reg[rd_ptr_reg].value;
    assign tokens.overflow   = queue_reg[rd_ptr_reg].overflow;
    assign tokens.last       = queue_reg[rd_ptr_reg].last;

endmodule
`default_nettype wire
